[rtl/facsc_pkg.sv]
// facsc_pkg: shared codes and types for the fully associative second-chance cache
// no dependencies
package facsc_pkg;

  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_PRELOAD = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  localparam int unsigned AddrWidth = 18;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned WordAddrWidth = AddrWidth - 2;

endpackage

[rtl/fully_assoc_cache_second_chance_top.sv]
// fully_assoc_cache_second_chance_top: write-back cache, clock replacement
// depends on facsc_pkg; line data and backing store are synchronous memories with registered reads
// flow: a write hit goes lookup, access, result; a read hit adds a line-read wait state;
//   a preload writes the store at lookup; a miss adds the line fill, plus a dirty write-back,
//   plus hand visits when all lines are full (each set reference bit cleared, then victim)
// one item at a time; the next is taken in the cycle after the result transfer
// reset: clears control and per-line flags, then sweeps the backing store to zero,
//   during which no item is accepted
module fully_assoc_cache_second_chance_top #(
  parameter int unsigned LINES          = 64,
  parameter int unsigned WORDS_PER_LINE = 16,
  parameter int unsigned STORE_WORDS    = 65536
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      operation_i,
  input  logic [facsc_pkg::AddrWidth-1:0] byte_address_i,
  input  logic [facsc_pkg::DataWidth-1:0] write_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [facsc_pkg::DataWidth-1:0] read_data_o,
  output logic                            hit_o,
  output logic                            cold_miss_o,
  output logic                            wrote_back_o
);
  import facsc_pkg::*;

  localparam int unsigned LW = $clog2(LINES);
  localparam int unsigned WW = $clog2(WORDS_PER_LINE);
  localparam int unsigned SW = $clog2(STORE_WORDS);
  localparam int unsigned TW = WordAddrWidth - WW;
  localparam int unsigned DW = LW + WW;
  localparam int unsigned DEPTH = LINES * WORDS_PER_LINE;

  localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_LOOK = 4'd2, S_HAND = 4'd3,
    S_WB = 4'd4, S_FILL = 4'd5, S_ACC = 4'd6, S_RDW = 4'd7, S_OUT = 4'd8;

  logic [3:0] state_q, state_d;

  // per-line flags in flops
  logic [TW-1:0] tag_q [LINES];
  logic [LINES-1:0] valid_q, dirty_q, ref_q;
  logic [LW-1:0] hand_q;
  logic [LW:0] filled_q;

  logic [1:0] op_q;
  logic [TW-1:0] itag_q;
  logic [WW-1:0] iword_q;
  logic [DataWidth-1:0] wdata_q;
  logic [LW-1:0] ln_q;
  logic [WW:0] cnt_q;
  logic [SW-1:0] clr_q;
  logic [TW-1:0] vtag_q;
  logic hit_q, cold_q, wb_q;
  logic [DataWidth-1:0] rd_q;

  // memories
  logic [DataWidth-1:0] line_mem [DEPTH];
  logic [DataWidth-1:0] store_mem [STORE_WORDS];
  logic [DataWidth-1:0] lrd_q, srd_q;
  logic lwe, swe, lre, sre;
  logic [DW-1:0] lwa, lra;
  logic [SW-1:0] swa, sra;
  logic [DataWidth-1:0] lwd, swd;

  always_ff @(posedge clk_i) begin
    if (lwe) line_mem[lwa] <= lwd;
    if (lre) lrd_q <= line_mem[lra];
  end
  always_ff @(posedge clk_i) begin
    if (swe) store_mem[swa] <= swd;
    if (sre) srd_q <= store_mem[sra];
  end

  // tag match
  logic found;
  logic [LW-1:0] found_ln;
  always_comb begin
    found = 1'b0;
    found_ln = '0;
    for (int i = LINES - 1; i >= 0; i--) begin
      if (valid_q[i] && tag_q[i] == itag_q) begin
        found = 1'b1;
        found_ln = LW'(i);
      end
    end
  end

  function automatic logic [SW-1:0] sidx(input logic [TW-1:0] t, input logic [WW-1:0] w);
    logic [WordAddrWidth-1:0] a;
    a = {t, w};
    return SW'(a);
  endfunction

  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign read_data_o = rd_q;
  assign hit_o = hit_q;
  assign cold_miss_o = cold_q;
  assign wrote_back_o = wb_q;

  logic [WW-1:0] cw;
  logic [LW-1:0] hand_nx;
  assign cw = cnt_q[WW-1:0];
  assign hand_nx = (hand_q == LW'(LINES - 1)) ? '0 : hand_q + 1'b1;

  always_comb begin
    state_d = state_q;
    lwe = 1'b0; lre = 1'b0; swe = 1'b0; sre = 1'b0;
    lwa = {ln_q, cw}; lra = {ln_q, cw}; lwd = srd_q;
    swa = sidx(vtag_q, cw); sra = sidx(itag_q, cw); swd = lrd_q;
    unique case (state_q)
      S_CLEAR: begin
        swe = 1'b1; swa = clr_q; swd = '0;
        if (clr_q == SW'(STORE_WORDS - 1)) state_d = S_IDLE;
      end
      S_IDLE: if (in_valid_i) state_d = S_LOOK;
      S_LOOK: begin
        if (op_q == OP_PRELOAD) begin
          swe = 1'b1; swa = SW'({itag_q, iword_q}); swd = wdata_q;
          state_d = S_OUT;
        end else if (op_q == OP_NONE) state_d = S_OUT;
        else if (found) state_d = S_ACC;
        else if (filled_q < (LW+1)'(LINES)) state_d = S_FILL;
        else state_d = S_HAND;
      end
      S_HAND: if (!ref_q[hand_q]) state_d = dirty_q[hand_q] ? S_WB : S_FILL;
      S_WB: begin
        // read line word cnt, write previous to store
        lre = (cnt_q < (WW+1)'(WORDS_PER_LINE));
        if (cnt_q != '0) begin
          swe = 1'b1; swa = sidx(vtag_q, cw - 1'b1);
        end
        if (cnt_q == (WW+1)'(WORDS_PER_LINE)) state_d = S_FILL;
      end
      S_FILL: begin
        sre = (cnt_q < (WW+1)'(WORDS_PER_LINE));
        if (cnt_q != '0) begin
          lwe = 1'b1; lwa = {ln_q, cw - 1'b1};
        end
        if (cnt_q == (WW+1)'(WORDS_PER_LINE)) state_d = S_ACC;
      end
      S_ACC: begin
        lwa = {ln_q, iword_q}; lra = {ln_q, iword_q}; lwd = wdata_q;
        if (op_q == OP_WRITE) begin
          lwe = 1'b1; state_d = S_OUT;
        end else begin
          lre = 1'b1; state_d = S_RDW;
        end
      end
      S_RDW: state_d = S_OUT;
      S_OUT: if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      op_q <= operation_i;
      itag_q <= byte_address_i[AddrWidth-1 -: TW];
      iword_q <= byte_address_i[2 +: WW];
      wdata_q <= write_data_i;
      rd_q <= '0;
    end
    if (state_q == S_RDW) rd_q <= lrd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      valid_q <= '0; dirty_q <= '0; ref_q <= '0;
      hand_q <= '0; filled_q <= '0; clr_q <= '0;
      cnt_q <= '0; ln_q <= '0; vtag_q <= '0;
      hit_q <= 1'b0; cold_q <= 1'b0; wb_q <= 1'b0;
      for (int i = 0; i < LINES; i++) tag_q[i] <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_CLEAR: clr_q <= clr_q + 1'b1;
        S_IDLE: if (in_valid_i) begin
          hit_q <= 1'b0; cold_q <= 1'b0; wb_q <= 1'b0;
        end
        S_LOOK: begin
          cnt_q <= '0;
          if (op_q == OP_READ || op_q == OP_WRITE) begin
            if (found) begin
              hit_q <= 1'b1; ln_q <= found_ln; ref_q[found_ln] <= 1'b1;
            end else if (filled_q < (LW+1)'(LINES)) begin
              cold_q <= 1'b1; ln_q <= LW'(filled_q); filled_q <= filled_q + 1'b1;
            end
          end
        end
        S_HAND: begin
          if (ref_q[hand_q]) ref_q[hand_q] <= 1'b0;
          else begin
            ln_q <= hand_q; vtag_q <= tag_q[hand_q];
            wb_q <= dirty_q[hand_q];
          end
          hand_q <= hand_nx;
        end
        S_WB: cnt_q <= (cnt_q == (WW+1)'(WORDS_PER_LINE)) ? '0 : cnt_q + 1'b1;
        S_FILL: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == (WW+1)'(WORDS_PER_LINE)) begin
            tag_q[ln_q] <= itag_q; valid_q[ln_q] <= 1'b1;
            dirty_q[ln_q] <= 1'b0; ref_q[ln_q] <= 1'b0;
          end
        end
        S_ACC: if (op_q == OP_WRITE) dirty_q[ln_q] <= 1'b1;
        default: ;
      endcase
    end
  end

endmodule

[rtl/facsc_checker.sv]
// facsc_checker: port-level checks for the cache top level
// no package dependencies; bound to fully_assoc_cache_second_chance_top
module facsc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic [31:0] read_data_o,
  input logic hit_o,
  input logic cold_miss_o,
  input logic wrote_back_o
);
  // hit and miss kinds exclude each other
  a_kinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && (cold_miss_o || wrote_back_o)))
    else $error("hit with miss flags");
  a_cold_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(cold_miss_o && wrote_back_o))
    else $error("cold miss with write-back");
  // no input transfer while a result waits
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken with result pending");
  // one item at a time: input closes right after a transfer
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input open right after a transfer");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_data_o))
    else $error("stalled result changed");
endmodule

bind fully_assoc_cache_second_chance_top facsc_checker u_facsc_checker (.*);
